### rtl/core/swac_pkg.sv
// swac_pkg: shared constants, types and the letter decode for the anagram counter
// no dependencies; imported by sliding_window_anagram_counter_unit and the testbench
`timescale 1ns / 1ps

package swac_pkg;

  localparam int MAX_WINDOW    = 4096;
  localparam int ALPHABET_SIZE = 52;
  localparam int CASE_SPAN     = 26;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int TOTAL_W = 32;

  localparam int IDX_W   = $clog2(MAX_WINDOW);
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int DIFF_W  = LEN_W + 1;
  localparam int BIN_W   = $clog2(ALPHABET_SIZE);
  localparam int AGREE_W = $clog2(ALPHABET_SIZE + 1);

  // result buffer entries, also the limit on items in flight
  localparam int RES_DEPTH = 2;
  localparam int RES_PW    = $clog2(RES_DEPTH);
  localparam int OCC_W     = $clog2(RES_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [SYM_W-1:0] CHAR_LO_Z = 8'h7a;
  localparam logic [SYM_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_UP_Z = 8'h5a;

  // window count minus pattern count for one letter
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic clear;  // restore reset state
    logic upd;    // bin of the incoming letter changes
    logic pat;    // pattern letter (count goes down) rather than text letter
    logic evict;  // oldest window letter leaves
    logic full;   // window full after this letter
    logic err;
  } item_ctl_t;

  typedef struct packed {
    logic               window_match;
    logic [TOTAL_W-1:0] match_total;
    logic               error;
  } result_t;

  // returns {is_letter, bin}
  function automatic logic [BIN_W:0] letter_bin(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] off;
    off = '0;
    if (sym >= CHAR_LO_A && sym <= CHAR_LO_Z) begin
      off = sym - CHAR_LO_A;
      return {1'b1, off[BIN_W-1:0]};
    end
    if (sym >= CHAR_UP_A && sym <= CHAR_UP_Z) begin
      off = sym - CHAR_UP_A + SYM_W'(CASE_SPAN);
      return {1'b1, off[BIN_W-1:0]};
    end
    return '0;
  endfunction

endpackage

### rtl/core/swac_ram.sv
// swac_ram: generic single-write, single-read RAM with registered read data
// read-first when both ports hit the same entry; no dependencies
`timescale 1ns / 1ps

module swac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/sliding_window_anagram_counter_unit.sv
// sliding_window_anagram_counter_unit: counts text windows that are anagrams of a pattern
// depends on swac_pkg and swac_ram
//
//   channel | direction | handshake                 | payload
//   item    | in        | item_valid / item_stall   | op, symbol
//   result  | out       | result_valid / result_stall | window_match, match_total, error
//
// a new item waits while the last one is in stage s1; the letter read of the leaving letter
// and the histogram read it addresses are in series, and the single histogram write port
// takes up to two writes per item; results enter the buffer from the update stage, up to 2 buffered
// reset is synchronous; histogram entries carry valid bits, no sweep
// a stalled result side holds item_stall high once two items are outstanding
`timescale 1ns / 1ps

module sliding_window_anagram_counter_unit
  import swac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [SYM_W-1:0]   symbol,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               window_match,
  output logic [TOTAL_W-1:0] match_total,
  output logic               error
);

  // value of a histogram entry, overlaid by the writes of the previous item
  function automatic diff_t fwd(
    input logic [BIN_W-1:0] addr,
    input diff_t            raw,
    input logic             raw_vld,
    input logic             pclr,
    input logic             w0_en,
    input logic [BIN_W-1:0] w0_addr,
    input diff_t            w0_val,
    input logic             w1_en,
    input logic [BIN_W-1:0] w1_addr,
    input diff_t            w1_val
  );
    diff_t v;
    v = raw_vld ? raw : '0;
    if (pclr) begin
      v = '0;
    end else if (w1_en && w1_addr == addr) begin
      v = w1_val;
    end else if (w0_en && w0_addr == addr) begin
      v = w0_val;
    end
    return v;
  endfunction

  // control state
  logic [LEN_W-1:0]   plen, plen_next;
  logic [LEN_W-1:0]   fill, fill_next;
  logic [IDX_W-1:0]   wp, wp_next;
  logic [AGREE_W-1:0] agreeing, agree_next;
  logic [TOTAL_W-1:0] match_count, count_next;
  logic [ALPHABET_SIZE-1:0] dvalid;

  // stage signals
  logic              item_xfer, res_xfer;
  logic              is_letter;
  logic [BIN_W-1:0]  in_bin;
  item_ctl_t         ctl0;
  logic              let_wr;
  logic [LEN_W:0]    idx_sum;
  logic [IDX_W-1:0]  old_idx;

  logic              s1_valid, s2_valid, s3_valid;
  item_ctl_t         s1_ctl, s2_ctl;
  logic [BIN_W-1:0]  s1_bin, s2_bin, s2_old, s3_addr;
  diff_t             s2_dn_raw, s3_val;
  logic              s2_dn_vld;

  logic [BIN_W-1:0]  letter_rd, old_bin;
  diff_t             ram_a_rd, ram_b_rd;
  logic              dvld_a, dvld_b;

  diff_t             dn, dold, nv, ov;
  logic              same;
  logic [1:0]        inc, dec;
  logic [AGREE_W:0]  agree_sum;
  logic              match;
  result_t           res;

  logic              diff_we;
  logic [BIN_W-1:0]  diff_waddr;
  diff_t             diff_wdata;

  logic              prev_clr, prev_w0_en, prev_w1_en;
  logic [BIN_W-1:0]  prev_w0_addr, prev_w1_addr;
  diff_t             prev_w0_val, prev_w1_val;

  result_t           res_buf [RES_DEPTH];
  logic [RES_PW-1:0] res_wp, res_rp;
  logic [OCC_W-1:0]  res_cnt, occ;

  // ---------------- intake: decode, window bookkeeping, letter memory ----------------
  assign item_xfer = item_valid && !item_stall;
  assign res_xfer  = result_valid && !result_stall;
  assign item_stall = s1_valid || (occ == OCC_W'(RES_DEPTH));
  assign {is_letter, in_bin} = letter_bin(symbol);

  always_comb begin
    ctl0      = '0;
    let_wr    = 1'b0;
    plen_next = plen;
    fill_next = fill;
    wp_next   = wp;
    unique case (op)
      OP_CLEAR: begin
        ctl0.clear = 1'b1;
        plen_next  = '0;
        fill_next  = '0;
        wp_next    = '0;
      end
      OP_PATTERN: begin
        if (!is_letter || plen >= LEN_W'(MAX_WINDOW)) begin
          ctl0.err = 1'b1;
        end else begin
          ctl0.upd  = 1'b1;
          ctl0.pat  = 1'b1;
          plen_next = plen + 1'b1;
        end
      end
      OP_TEXT: begin
        if (!is_letter) begin
          ctl0.err = 1'b1;
        end else if (plen != '0) begin
          ctl0.upd   = 1'b1;
          let_wr     = 1'b1;
          wp_next    = (wp == IDX_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
          ctl0.evict = (fill >= plen);
          ctl0.full  = (fill >= plen) || ((fill + 1'b1) == plen);
          if (fill < plen) begin
            fill_next = fill + 1'b1;
          end
        end
      end
      default: begin
        ctl0.err = 1'b1;
      end
    endcase
  end

  // oldest letter sits fill places behind the write pointer
  assign idx_sum = (LEN_W + 1)'(wp) + (LEN_W + 1)'(MAX_WINDOW) - (LEN_W + 1)'(fill);
  assign old_idx = (idx_sum >= (LEN_W + 1)'(MAX_WINDOW))
                 ? IDX_W'(idx_sum - (LEN_W + 1)'(MAX_WINDOW)) : IDX_W'(idx_sum);

  swac_ram #(.WIDTH(BIN_W), .DEPTH(MAX_WINDOW)) u_letters (
    .clk     (clk),
    .wr_en   (item_xfer && let_wr),
    .wr_addr (wp),
    .wr_data (in_bin),
    .rd_addr (old_idx),
    .rd_data (letter_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      fill <= '0;
      wp   <= '0;
    end else if (item_xfer) begin
      plen <= plen_next;
      fill <= fill_next;
      wp   <= wp_next;
    end
  end

  // ---------------- histogram memory: two copies for two read ports ----------------
  assign old_bin = (letter_rd >= BIN_W'(ALPHABET_SIZE)) ? '0 : letter_rd;

  swac_ram #(.WIDTH(DIFF_W), .DEPTH(ALPHABET_SIZE)) u_diff_a (
    .clk     (clk),
    .wr_en   (diff_we),
    .wr_addr (diff_waddr),
    .wr_data (diff_wdata),
    .rd_addr (old_bin),
    .rd_data (ram_a_rd)
  );

  swac_ram #(.WIDTH(DIFF_W), .DEPTH(ALPHABET_SIZE)) u_diff_b (
    .clk     (clk),
    .wr_en   (diff_we),
    .wr_addr (diff_waddr),
    .wr_data (diff_wdata),
    .rd_addr (in_bin),
    .rd_data (ram_b_rd)
  );

  always_ff @(posedge clk) begin
    dvld_b <= dvalid[in_bin];
    dvld_a <= dvalid[old_bin];
  end

  always_ff @(posedge clk) begin
    if (rst || (s2_valid && s2_ctl.clear)) begin
      dvalid <= '0;
    end else if (diff_we) begin
      dvalid[diff_waddr] <= 1'b1;
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= item_xfer;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_ctl.evict && !same;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl    <= ctl0;
    s1_bin    <= in_bin;
    s2_ctl    <= s1_ctl;
    s2_bin    <= s1_bin;
    s2_old    <= old_bin;
    s2_dn_raw <= ram_b_rd;
    s2_dn_vld <= dvld_b;
    s3_addr   <= s2_old;
    s3_val    <= ov;
  end

  // ---------------- update: new counts, agreeing bins, match ----------------
  always_comb begin
    dn   = fwd(s2_bin, s2_dn_raw, s2_dn_vld, prev_clr, prev_w0_en, prev_w0_addr,
               prev_w0_val, prev_w1_en, prev_w1_addr, prev_w1_val);
    dold = fwd(s2_old, ram_a_rd, dvld_a, prev_clr, prev_w0_en, prev_w0_addr,
               prev_w0_val, prev_w1_en, prev_w1_addr, prev_w1_val);
    same = s2_ctl.evict && (s2_old == s2_bin);
    inc  = '0;
    dec  = '0;
    if (s2_ctl.pat) begin
      nv = dn - diff_t'(1);
    end else if (same) begin
      nv = dn;
    end else begin
      nv = dn + diff_t'(1);
    end
    ov = same ? dn : dold - diff_t'(1);
    if (s2_ctl.upd && !same) begin
      dec = dec + 2'((dn == '0));
      inc = inc + 2'((nv == '0));
    end
    if (s2_ctl.evict && !same) begin
      dec = dec + 2'((dold == '0));
      inc = inc + 2'((ov == '0));
    end
    agree_sum  = (AGREE_W + 1)'(agreeing) + (AGREE_W + 1)'(inc) - (AGREE_W + 1)'(dec);
    agree_next = agree_sum[AGREE_W-1:0];
    match      = s2_ctl.full && (agree_next == AGREE_W'(ALPHABET_SIZE));
    if (s2_ctl.clear) begin
      count_next = '0;
    end else if (match && match_count != '1) begin
      count_next = match_count + 1'b1;
    end else begin
      count_next = match_count;
    end
    res = s2_ctl.clear ? '0 : result_t'{window_match: match, match_total: count_next,
                                        error: s2_ctl.err};
  end

  // new bin is written in the update cycle, the leaving bin in the cycle after
  assign diff_we    = (s2_valid && s2_ctl.upd) || s3_valid;
  assign diff_waddr = s3_valid ? s3_addr : s2_bin;
  assign diff_wdata = s3_valid ? s3_val : nv;

  always_ff @(posedge clk) begin
    if (rst) begin
      agreeing    <= AGREE_W'(ALPHABET_SIZE);
      match_count <= '0;
      prev_clr    <= 1'b0;
      prev_w0_en  <= 1'b0;
      prev_w1_en  <= 1'b0;
    end else if (s2_valid) begin
      agreeing    <= s2_ctl.clear ? AGREE_W'(ALPHABET_SIZE) : agree_next;
      match_count <= count_next;
      prev_clr    <= s2_ctl.clear;
      prev_w0_en  <= s2_ctl.upd;
      prev_w1_en  <= s2_ctl.evict && !same;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      prev_w0_addr <= s2_bin;
      prev_w0_val  <= nv;
      prev_w1_addr <= s2_old;
      prev_w1_val  <= ov;
    end
  end

  // ---------------- result buffer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_wp  <= '0;
      res_rp  <= '0;
      res_cnt <= '0;
      occ     <= '0;
    end else begin
      if (s2_valid) begin
        res_wp <= res_wp + 1'b1;
      end
      if (res_xfer) begin
        res_rp <= res_rp + 1'b1;
      end
      res_cnt <= res_cnt + OCC_W'(s2_valid) - OCC_W'(res_xfer);
      occ     <= occ + OCC_W'(item_xfer) - OCC_W'(res_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      res_buf[res_wp] <= res;
    end
  end

  assign result_valid = (res_cnt != '0);
  assign window_match = res_buf[res_rp].window_match;
  assign match_total  = res_buf[res_rp].match_total;
  assign error        = res_buf[res_rp].error;

  // ---------------- checks ----------------
  a_no_buf_overflow: assert property (@(posedge clk) disable iff (rst)
    !(s2_valid && res_cnt == OCC_W'(RES_DEPTH) && !res_xfer))
    else $error("result buffer written while full");

  a_one_write_port: assert property (@(posedge clk) disable iff (rst)
    !(s3_valid && s2_valid && s2_ctl.upd))
    else $error("two histogram writes in one cycle");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    occ == OCC_W'(s1_valid) + OCC_W'(s2_valid) + res_cnt)
    else $error("outstanding count out of step with pipeline");

  a_agree_range: assert property (@(posedge clk) disable iff (rst)
    agreeing <= AGREE_W'(ALPHABET_SIZE))
    else $error("agreeing bins above alphabet size");

  a_fill_le_plen: assert property (@(posedge clk) disable iff (rst)
    fill <= plen)
    else $error("window fill beyond pattern length");

endmodule

### sim/testbench.sv
// testbench: self-checking bench for sliding_window_anagram_counter_unit
// depends on swac_pkg and the unit; directed table first, then random letter sequences
`timescale 1ns / 1ps

module testbench
  import swac_pkg::*;
();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [SYM_W-1:0] sym;
    int               reps;
    bit               typed;
    result_t          want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [OP_W-1:0]    op = '0;
  logic [SYM_W-1:0]   symbol = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               window_match;
  logic [TOTAL_W-1:0] match_total;
  logic               error;

  // predictor state
  logic [LEN_W-1:0]   pat_hist [ALPHABET_SIZE];
  logic [LEN_W-1:0]   win_hist [ALPHABET_SIZE];
  logic [BIN_W-1:0]   win_mem [MAX_WINDOW];
  int                 bins_agree;
  logic [IDX_W-1:0]   wr_ptr;
  logic [LEN_W-1:0]   pat_len;
  logic [LEN_W-1:0]   win_fill;
  logic [TOTAL_W-1:0] match_cnt;

  result_t expected_q [$];
  int      mismatch_count = 0;
  int      useful_items;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_request = 1'b0;
  bit      hold_taken = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  int idle_by_phase  [4] = '{0, 53, 0, 8};
  int stall_by_phase [4] = '{0, 0, 53, 8};

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_CLEAR,   8'h00, 1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_UNUSED,  8'hff, 1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    // text with no pattern yet is taken but never stored
    '{OP_TEXT,    "a",   1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_PATTERN, 8'h00, 1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    '{OP_PATTERN, 8'h60, 1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    '{OP_TEXT,    8'h7b, 1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    '{OP_TEXT,    8'h40, 1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    '{OP_PATTERN, 8'h5b, 1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    '{OP_PATTERN, "a",   1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_PATTERN, "z",   1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_PATTERN, "A",   1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_PATTERN, "Z",   1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_TEXT,    "Z",   1,    1'b0, '0},
    '{OP_TEXT,    "A",   1,    1'b0, '0},
    '{OP_TEXT,    "z",   1,    1'b0, '0},
    '{OP_TEXT,    "a",   1,    1'b0, '0},
    '{OP_TEXT,    "Z",   1,    1'b0, '0},
    // pattern grows after text: window refills before it can match again
    '{OP_PATTERN, "m",   1,    1'b0, '0},
    '{OP_TEXT,    "m",   1,    1'b0, '0},
    '{OP_TEXT,    8'hff, 1,    1'b0, '0},
    '{OP_CLEAR,   8'hff, 1,    1'b1, '{1'b0, 32'd0, 1'b0}},
    '{OP_PATTERN, "q",   4096, 1'b0, '0},
    // pattern at full capacity
    '{OP_PATTERN, "Q",   1,    1'b1, '{1'b0, 32'd0, 1'b1}},
    // full-size window, write pointer wraps
    '{OP_TEXT,    "q",   4200, 1'b0, '0},
    '{OP_CLEAR,   8'h00, 1,    1'b1, '{1'b0, 32'd0, 1'b0}}
  };

  sliding_window_anagram_counter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .symbol       (symbol),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .window_match (window_match),
    .match_total  (match_total),
    .error        (error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int char_to_bin(input logic [SYM_W-1:0] s);
    if (s >= CHAR_LO_A && s <= CHAR_LO_Z) return int'(s - CHAR_LO_A);
    if (s >= CHAR_UP_A && s <= CHAR_UP_Z) return int'(s - CHAR_UP_A) + CASE_SPAN;
    return -1;
  endfunction

  function automatic logic [SYM_W-1:0] bin_to_char(input int b);
    if (b < CASE_SPAN) return CHAR_LO_A + SYM_W'(b);
    return CHAR_UP_A + SYM_W'(b - CASE_SPAN);
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      pat_hist[i] = '0;
      win_hist[i] = '0;
    end
    bins_agree = ALPHABET_SIZE;
    wr_ptr     = '0;
    pat_len    = '0;
    win_fill   = '0;
    match_cnt  = '0;
  endfunction

  // move one bin up or down and keep the agreeing-bin count in step
  function automatic void shift_bin(input bit in_pattern, input int b, input bit up);
    bit was_equal;
    was_equal = (pat_hist[b] == win_hist[b]);
    if (in_pattern) pat_hist[b] = up ? pat_hist[b] + 1'b1 : pat_hist[b] - 1'b1;
    else win_hist[b] = up ? win_hist[b] + 1'b1 : win_hist[b] - 1'b1;
    if (was_equal && pat_hist[b] != win_hist[b]) bins_agree--;
    else if (!was_equal && pat_hist[b] == win_hist[b]) bins_agree++;
  endfunction

  function automatic result_t anagram_predict(input logic [OP_W-1:0] o,
                                              input logic [SYM_W-1:0] s);
    result_t          r;
    int               b;
    logic [IDX_W-1:0] oldest;
    r = '0;
    b = char_to_bin(s);
    if (o == OP_CLEAR) begin
      clear_counts();
    end else if (o == OP_UNUSED || b < 0) begin
      r.error = 1'b1;
    end else if (o == OP_PATTERN) begin
      if (pat_len >= MAX_WINDOW) begin
        r.error = 1'b1;
      end else begin
        shift_bin(1'b1, b, 1'b1);
        pat_len++;
      end
    end else if (pat_len > 0) begin
      if (win_fill >= pat_len) begin
        // a window of MAX_WINDOW letters wraps onto the write pointer itself
        oldest = wr_ptr - win_fill[IDX_W-1:0];
        shift_bin(1'b0, win_mem[oldest], 1'b0);
      end else begin
        win_fill++;
      end
      win_mem[wr_ptr] = BIN_W'(b);
      wr_ptr++;
      shift_bin(1'b0, b, 1'b1);
      if (win_fill == pat_len && bins_agree == ALPHABET_SIZE) begin
        r.window_match = 1'b1;
        if (match_cnt != '1) match_cnt++;
      end
    end
    r.match_total = match_cnt;
    return r;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s,
                           input bit typed, input result_t want);
    result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    symbol     <= s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = anagram_predict(o, s);
    expected_q.push_back(typed ? want : pred);
    if (!pred.error) useful_items++;
  endtask

  // sender goes quiet until every outstanding result has arrived
  task automatic drain_results();
    item_valid <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk);
  endtask

  // usually a clear, then a short pattern from a three-letter pool, then text mostly from the same pool
  task automatic run_sequence();
    int pool [3];
    int plen;
    int tlen;
    int pick;
    for (int k = 0; k < 3; k++) pool[k] = $urandom_range(ALPHABET_SIZE - 1);
    if ($urandom_range(4) != 0) send_item(OP_CLEAR, SYM_W'($urandom), 1'b0, '0);
    plen = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
    repeat (plen) send_item(OP_PATTERN, bin_to_char(pool[$urandom_range(2)]), 1'b0, '0);
    tlen = $urandom_range(40, 10);
    repeat (tlen) begin
      pick = $urandom_range(99);
      if (pick < 84)
        send_item(OP_TEXT, bin_to_char(pool[$urandom_range(2)]), 1'b0, '0);
      else if (pick < 88)
        send_item(OP_PATTERN, bin_to_char(pool[$urandom_range(2)]), 1'b0, '0);
      else if (pick < 92)
        send_item(OP_TEXT, SYM_W'($urandom), 1'b0, '0);
      else if (pick < 96)
        send_item(OP_PATTERN, SYM_W'($urandom), 1'b0, '0);
      else
        send_item(OP_W'($urandom_range(3)), SYM_W'($urandom), 1'b0, '0);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: match %0b total %0d error %0b",
               $time, window_match, match_total, error);
      mismatch_count++;
    end else begin
      want = expected_q.pop_front();
      if (window_match !== want.window_match) begin
        $display("%0t: window_match expected %0b got %0b",
                 $time, want.window_match, window_match);
        mismatch_count++;
      end
      if (match_total !== want.match_total) begin
        $display("%0t: match_total expected %0d got %0d",
                 $time, want.match_total, match_total);
        mismatch_count++;
      end
      if (error !== want.error) begin
        $display("%0t: error expected %0b got %0b", $time, want.error, error);
        mismatch_count++;
      end
    end
  endtask

  // result side: check each transfer, then pick the stall for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) check_result();
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_counts();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 8;
    recv_stall_pct = 8;
    foreach (directed_rows[i]) begin
      for (int n = 0; n < directed_rows[i].reps; n++)
        send_item(directed_rows[i].opcode, directed_rows[i].sym,
                  directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      // long hold-off on the result side while the sender keeps offering items
      if (ph == 0) hold_request = 1'b1;
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS / 4) run_sequence();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
rtl/core/swac_pkg.sv
rtl/core/swac_ram.sv
rtl/core/sliding_window_anagram_counter_unit.sv
sim/testbench.sv
